// ===== rtl/core/dlt_pkg.sv =====
// ----------------------------------------------------------------------------
// dlt_pkg: shared types and codes of the lease tracker
// Word formats, item and event codes, controller states and the command and
// status groups that join the controller and the datapath.
// ----------------------------------------------------------------------------
package dlt_pkg;

   // item kinds
   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_RELEASE = 2'd1;
   localparam logic [1:0] KIND_CHECK   = 2'd2;
   localparam logic [1:0] KIND_UNUSED  = 2'd3;

   // event codes
   localparam logic [2:0] EV_ADDED    = 3'd0;
   localparam logic [2:0] EV_UPDATED  = 3'd1;
   localparam logic [2:0] EV_RELEASED = 3'd2;
   localparam logic [2:0] EV_EXPIRED  = 3'd3;
   localparam logic [2:0] EV_IGNORED  = 3'd4;
   localparam logic [2:0] EV_FULL     = 3'd5;
   localparam logic [2:0] EV_DONE     = 3'd6;

   // register word select (paddr[2])
   localparam int unsigned CSR_ADDR_W    = 3;
   localparam logic        CSR_LIVE_MODE = 1'b0;

   typedef struct packed {
      logic [1:0]  kind;
      logic [31:0] address;
      logic [31:0] packet_time;
      logic [31:0] lease_seconds;
      logic [31:0] now_time;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] entry_addr;
      logic [31:0] entry_expiry;
      logic        last;
   } rsp_word_type;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] expiry;
   } slot_word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_READ,
      ST_COMPARE,
      ST_RESULT,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      SEL_DIRECT,
      SEL_LOOKUP,
      SEL_EXPIRED,
      SEL_DONE
   } res_sel_type;

   typedef struct packed {
      logic        capture;
      logic        read;
      logic        compare;
      logic        commit;
      logic        load;
      res_sel_type sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       drop;
      logic       scan_last;
      logic       expire_hit;
      logic       out_free;
   } dp_status_type;

endpackage

// ===== rtl/core/dlt_ram.sv =====
// ----------------------------------------------------------------------------
// dlt_ram: generic single-port-write RAM
// One write port, one read port with registered read data held when idle.
// ----------------------------------------------------------------------------
module dlt_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dlt_datapath.sv =====
// ----------------------------------------------------------------------------
// dlt_datapath: lease table storage, scan logic and result register
// Holds the current item, the slot valid bits, the slot RAM, the scan index
// with its hit and free-slot trackers, and the result word register.
// ----------------------------------------------------------------------------
module dlt_datapath
   import dlt_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  ctrl_cmd_type  cmd,
   output dp_status_type status,
   input  req_word_type  req_data,
   input  logic          live_mode,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output rsp_word_type  rsp_data
);

   localparam int unsigned IDX_W = $clog2(TABLE_DEPTH);
   localparam int unsigned SLOT_W = $bits(slot_word_type);

   req_word_type        item_ff;
   logic [31:0]         exp_ff, exp_in;
   logic [32:0]         exp_sum;
   logic [IDX_W-1:0]    idx_ff;
   logic                hit_ff, free_ff;
   logic [IDX_W-1:0]    hit_idx_ff, free_idx_ff;
   logic [31:0]         hit_exp_ff;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic                rsp_valid_ff;
   rsp_word_type        rsp_ff, rsp_in;
   slot_word_type       rd_word, wr_word;
   logic [SLOT_W-1:0]   rd_bits;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic                cur_valid, addr_match, out_free, is_check;

   // saturated expiry of the incoming word
   assign exp_sum = {1'b0, req_data.packet_time} + {1'b0, req_data.lease_seconds};
   assign exp_in  = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];

   dlt_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (TABLE_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_word),
      .rd_en   (cmd.read),
      .rd_addr (idx_ff),
      .rd_data (rd_bits)
   );

   assign rd_word    = slot_word_type'(rd_bits);
   assign cur_valid  = valid_ff[idx_ff];
   assign addr_match = cur_valid && (rd_word.address == item_ff.address);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign is_check   = (item_ff.kind == KIND_CHECK);

   assign status.kind       = item_ff.kind;
   assign status.drop       = (item_ff.kind == KIND_ACK) && live_mode &&
                              (exp_ff <= item_ff.now_time);
   assign status.scan_last  = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign status.expire_hit = cur_valid && (rd_word.expiry != 32'd0) &&
                              (rd_word.expiry <= item_ff.now_time);
   assign status.out_free   = out_free;

   // slot RAM writes happen with the result load of an ack
   assign wr_en   = cmd.commit && (item_ff.kind == KIND_ACK) && (hit_ff || free_ff);
   assign wr_addr = hit_ff ? hit_idx_ff : free_idx_ff;
   assign wr_word = '{address: item_ff.address, expiry: exp_ff};

   always_comb begin
      valid_in = valid_ff;
      if (cmd.compare && is_check && status.expire_hit) begin
         valid_in[idx_ff] = 1'b0;
      end
      if (cmd.commit) begin
         if (item_ff.kind == KIND_ACK && !hit_ff && free_ff) begin
            valid_in[free_idx_ff] = 1'b1;
         end else if (item_ff.kind == KIND_RELEASE && hit_ff) begin
            valid_in[hit_idx_ff] = 1'b0;
         end
      end
   end

   always_comb begin
      rsp_in = '{event_res: EV_IGNORED, entry_addr: item_ff.address,
                 entry_expiry: 32'd0, last: 1'b1};
      case (cmd.sel)
         SEL_DIRECT: begin
            if (item_ff.kind == KIND_ACK) begin
               rsp_in.entry_expiry = exp_ff;
            end
         end
         SEL_LOOKUP: begin
            if (item_ff.kind == KIND_ACK) begin
               rsp_in.entry_expiry = exp_ff;
               if (hit_ff) begin
                  rsp_in.event_res = EV_UPDATED;
               end else if (free_ff) begin
                  rsp_in.event_res = EV_ADDED;
               end else begin
                  rsp_in.event_res = EV_FULL;
               end
            end else if (hit_ff) begin
               rsp_in.event_res    = EV_RELEASED;
               rsp_in.entry_expiry = hit_exp_ff;
            end
         end
         SEL_EXPIRED: begin
            rsp_in = '{event_res: EV_EXPIRED, entry_addr: rd_word.address,
                       entry_expiry: rd_word.expiry, last: 1'b0};
         end
         default: begin
            rsp_in = '{event_res: EV_DONE, entry_addr: 32'd0,
                       entry_expiry: 32'd0, last: 1'b1};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
         exp_ff  <= exp_in;
         idx_ff  <= '0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.compare) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (addr_match && !hit_ff) begin
            hit_ff     <= 1'b1;
            hit_idx_ff <= idx_ff;
            hit_exp_ff <= rd_word.expiry;
         end
         if (!cur_valid && !free_ff) begin
            free_ff     <= 1'b1;
            free_idx_ff <= idx_ff;
         end
      end
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a result that is not the final one of its item is always an expiry
   a_nonlast_expired: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> rsp_ff.event_res == EV_EXPIRED)
      else $error("non-final result with wrong event");

   // a table write during a scan would corrupt the lookup
   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmd.compare |-> !wr_en)
      else $error("slot write while scanning");

endmodule

// ===== rtl/core/dlt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlt_ctrl: sequencer of the lease tracker
// Takes one word at a time, scans with a read and a compare state per slot
// and issues result loads when the result register can take them.
// ----------------------------------------------------------------------------
module dlt_ctrl
   import dlt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '{capture: 1'b0, read: 1'b0, compare: 1'b0, commit: 1'b0,
                    load: 1'b0, sel: SEL_DIRECT};
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.kind == KIND_UNUSED || status.drop) begin
               state_in = ST_RESULT;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (status.kind == KIND_CHECK) begin
               // an expiring slot waits here until its word can be loaded
               if (!status.expire_hit || status.out_free) begin
                  cmd.compare = 1'b1;
                  cmd.load    = status.expire_hit;
                  cmd.sel     = SEL_EXPIRED;
                  state_in    = status.scan_last ? ST_DONE : ST_READ;
               end
            end else begin
               cmd.compare = 1'b1;
               state_in    = status.scan_last ? ST_RESULT : ST_READ;
            end
         end
         ST_RESULT: begin
            if (status.kind == KIND_UNUSED || status.drop) begin
               cmd.sel = SEL_DIRECT;
            end else begin
               cmd.sel    = SEL_LOOKUP;
               cmd.commit = status.out_free;
            end
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            cmd.sel = SEL_DONE;
            if (status.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> status.out_free)
      else $error("result load while result register busy");

   a_accept_to_decide: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_DECIDE)
      else $error("accepted word not decoded");

endmodule

// ===== rtl/core/dhcp_lease_tracker.sv =====
// ----------------------------------------------------------------------------
// dhcp_lease_tracker: lease table with expiry sweep
// Word in on req_ (ack, release, expiry check), event words out on rsp_,
// live_mode register on the APB-style port at byte address 0.
//
// One word is worked at a time; req_ready is high only while the sequencer
// is idle, but it is raised again while a finished result still waits in
// the result register. Each lookup or sweep reads the slot RAM once per
// slot, in a read state and then a compare state. An ack or release then
// loads its result in the result state; an ack dropped in live mode or an
// unused kind goes from the decide state straight to the result state.
// The next word can be taken in the cycle after the result is loaded.
// An expiry check gives one expired word per removed entry, then a done
// word with last set. If rsp_ready is held low, the sweep stops at the
// next expiring slot and a lookup stops before its result; nothing is lost.
// Reset clears all slot valid bits at once (no clearing pass) and
// live_mode; the RAM contents are not reset.
// ----------------------------------------------------------------------------
module dhcp_lease_tracker
   import dlt_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_word_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_word_type          rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          live_mode_ff;

   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         live_mode_ff <= 1'b0;
      end else if (psel && penable && pwrite && pready &&
                   paddr[CSR_ADDR_W-1] == CSR_LIVE_MODE) begin
         live_mode_ff <= pwdata[0];
      end
   end

   assign prdata = (paddr[CSR_ADDR_W-1] == CSR_LIVE_MODE) ? {31'd0, live_mode_ff} : 32'd0;

   dlt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dlt_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .live_mode (live_mode_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
